>>> rtl/bfs_pkg.sv
`default_nettype none
package bfs_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_HALFH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BORDER      = 2'd3;

    localparam logic [12:0] IMAGE_WIDTH_RESET = 13'd256;
    localparam logic [3:0]  HALF_WIDTH_RESET  = 4'd1;
    localparam logic [3:0]  BOX_HALFH_RESET   = 4'd1;
    localparam logic [7:0]  BORDER_RESET      = 8'd0;

    localparam int ROW_W = 14;
    localparam logic [ROW_W-1:0] ROW_MAX = 14'h3FFF;

    localparam int CS_W  = 13;
    localparam int SUM_W = 18;

    typedef struct packed {
        logic [7:0] pixel;
        logic       beyond_bottom;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] box_sum;
        logic [11:0]      out_col;
        logic             last_in_run;
    } out_item_t;

endpackage
`default_nettype wire

>>> rtl/box_filter_sum.sv
`default_nettype none
// Streaming box sum over 8-bit raster pixels. One pixel transaction is taken per cycle when
// nothing holds the input off; each pixel makes a single read-modify-write pass over the
// column-sum and line memories, read as it is accepted and written back when it steps on.
// The row's last pixel also drains the right-edge centres, one per cycle through the single
// output register, and no new pixel is taken before the last drain step. A stalled output
// holds the pipeline. Input is held off while a configuration write is in progress and in
// the cycle after, while the derived border terms settle. Memories need no clearing.
module box_filter_sum #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HALF  = 15
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire [bfs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [bfs_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire bfs_pkg::in_item_t               in_data,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output bfs_pkg::out_item_t                   out_data
);

    localparam int EFF_HALF = (MAX_HALF < 15) ? MAX_HALF : 15;
    localparam int SLOTS    = 2 * EFF_HALF + 1;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int HALF_W   = $clog2(EFF_HALF + 1);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WID_W    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W    = (WID_W > 13) ? WID_W : 13;
    localparam int LS_DEPTH = SLOTS * MAX_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int VC_W     = ((COL_W > HALF_W) ? COL_W : HALF_W) + 2;
    localparam int CS_W     = bfs_pkg::CS_W;
    localparam int SUM_W    = bfs_pkg::SUM_W;
    localparam int ROW_W    = bfs_pkg::ROW_W;

    logic [12:0] image_width_reg;
    logic [3:0]  half_width_reg;
    logic [3:0]  box_halfh_reg;
    logic [7:0]  border_reg;
    logic        settle_reg;

    logic [CS_W-1:0]  bcol_reg;
    logic [CS_W-1:0]  hb_reg;
    logic [SUM_W-1:0] w2bcol_reg;

    logic [HALF_W-1:0] w_eff;
    logic [HALF_W-1:0] h_eff;
    logic [HALF_W:0]   rows_eff;
    logic [WID_W-1:0]  width_eff;
    logic [CMP_W-1:0]  iw_ext;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [LS_AW-1:0]  base_reg;

    logic              b_valid_reg;
    logic              b_drain_reg;
    logic [HALF_W-1:0] k_reg;
    logic [COL_W-1:0]  b_col_reg;
    logic [7:0]        b_v_reg;
    logic              b_row0_reg;
    logic              b_old_border_reg;
    logic              b_emit_reg;
    logic              b_row_end_reg;
    logic [LS_AW-1:0]  b_ls_addr_reg;

    logic [7:0]      ls_mem [LS_DEPTH];
    logic [CS_W-1:0] cs_mem [MAX_WIDTH];
    logic [7:0]      ls_q_reg;
    logic [CS_W-1:0] cs_q_reg;

    logic [CS_W-1:0]  hist_reg [SLOTS];
    logic [SUM_W-1:0] win_reg;

    logic               out_valid_reg;
    bfs_pkg::out_item_t out_data_reg;

    logic             accept;
    logic             step;
    logic             step_last;
    logic [COL_W:0]   col_p1;
    logic             row_end_a;
    logic [LS_AW-1:0] ls_rd_addr;
    logic             slot_wrap;

    logic [7:0]       old_v;
    logic [CS_W-1:0]  cs_new;
    logic [CS_W-1:0]  tap;
    logic [VC_W-1:0]  col_ext;
    logic [VC_W-1:0]  vc;
    logic [VC_W-1:0]  span_ext;
    logic [VC_W-1:0]  w_ext;
    logic [CS_W-1:0]  leave_c;
    logic [CS_W-1:0]  leave_d;
    logic [SUM_W-1:0] win_c;
    logic [SUM_W-1:0] win_d;
    logic             produce;
    logic             res_last;
    logic [SUM_W-1:0] res_sum;
    logic [11:0]      res_col;

    always_comb
    begin
        w_eff = (half_width_reg > 4'(EFF_HALF)) ? HALF_W'(EFF_HALF) : HALF_W'(half_width_reg);
        h_eff = (box_halfh_reg > 4'(EFF_HALF)) ? HALF_W'(EFF_HALF) : HALF_W'(box_halfh_reg);
        rows_eff = {h_eff, 1'b1};
        iw_ext = CMP_W'(image_width_reg);
        if (iw_ext < CMP_W'(2))
        begin
            width_eff = WID_W'(2);
        end
        else if (iw_ext > CMP_W'(MAX_WIDTH))
        begin
            width_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WID_W'(iw_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= bfs_pkg::IMAGE_WIDTH_RESET;
            half_width_reg  <= bfs_pkg::HALF_WIDTH_RESET;
            box_halfh_reg   <= bfs_pkg::BOX_HALFH_RESET;
            border_reg      <= bfs_pkg::BORDER_RESET;
            settle_reg      <= 1'b0;
            bcol_reg        <= '0;
            hb_reg          <= '0;
            w2bcol_reg      <= '0;
        end
        else
        begin
            settle_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_index)
                    bfs_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data[12:0];
                    bfs_pkg::REG_HALF_WIDTH:  half_width_reg  <= cfg_data[3:0];
                    bfs_pkg::REG_BOX_HALFH:   box_halfh_reg   <= cfg_data[3:0];
                    bfs_pkg::REG_BORDER:      border_reg      <= cfg_data[7:0];
                    default: ;
                endcase
            end
            bcol_reg   <= CS_W'(rows_eff) * CS_W'(border_reg);
            hb_reg     <= CS_W'({h_eff, 1'b0}) * CS_W'(border_reg);
            w2bcol_reg <= SUM_W'({w_eff, 1'b0}) * SUM_W'(bcol_reg);
        end
    end

    always_comb
    begin
        col_ext  = VC_W'(b_col_reg);
        vc       = col_ext + VC_W'(k_reg);
        span_ext = VC_W'({w_eff, 1'b1});
        w_ext    = VC_W'(w_eff);
        tap      = hist_reg[SLOT_W'({w_eff, 1'b0})];

        old_v = b_old_border_reg ? border_reg : ls_q_reg;
        if (b_row0_reg)
        begin
            cs_new = hb_reg + CS_W'(b_v_reg);
        end
        else
        begin
            cs_new = cs_q_reg + CS_W'(b_v_reg) - CS_W'(old_v);
        end

        leave_c = (col_ext >= span_ext) ? tap : bcol_reg;
        if (b_col_reg == '0)
        begin
            win_c = w2bcol_reg + SUM_W'(cs_new);
        end
        else
        begin
            win_c = win_reg + SUM_W'(cs_new) - SUM_W'(leave_c);
        end

        leave_d = (vc >= span_ext) ? tap : bcol_reg;
        win_d   = win_reg + SUM_W'(bcol_reg) - SUM_W'(leave_d);

        if (b_drain_reg)
        begin
            produce   = b_emit_reg && (vc >= w_ext);
            res_sum   = win_d;
            res_col   = 12'(vc - w_ext);
            res_last  = (k_reg == w_eff);
            step_last = (k_reg == w_eff);
        end
        else
        begin
            produce   = b_emit_reg && (col_ext >= w_ext);
            res_sum   = win_c;
            res_col   = 12'(col_ext - w_ext);
            res_last  = !(b_row_end_reg && (w_eff != '0));
            step_last = !b_row_end_reg || (w_eff == '0);
        end

        step     = b_valid_reg && (!out_valid_reg || out_ready);
        in_ready = !settle_reg && !cfg_we && (!b_valid_reg || (step && step_last));
        accept   = in_valid && in_ready;

        col_p1     = {1'b0, col_reg} + (COL_W+1)'(1);
        row_end_a  = col_p1 >= (COL_W+1)'(width_eff);
        ls_rd_addr = base_reg + LS_AW'(col_reg);
        slot_wrap  = ((SLOT_W+1)'(slot_reg) + (SLOT_W+1)'(1)) >= (SLOT_W+1)'(rows_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            slot_reg    <= '0;
            base_reg    <= '0;
            b_valid_reg <= 1'b0;
            b_drain_reg <= 1'b0;
            k_reg       <= '0;
            win_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (row_end_a)
                begin
                    col_reg <= '0;
                    if (row_reg < bfs_pkg::ROW_MAX)
                    begin
                        row_reg <= row_reg + ROW_W'(1);
                    end
                    if (slot_wrap)
                    begin
                        slot_reg <= '0;
                        base_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                        base_reg <= base_reg + LS_AW'(MAX_WIDTH);
                    end
                end
                else
                begin
                    col_reg <= col_p1[COL_W-1:0];
                end
            end

            if (step)
            begin
                win_reg <= b_drain_reg ? win_d : win_c;
            end

            if (accept)
            begin
                b_valid_reg <= 1'b1;
                b_drain_reg <= 1'b0;
                k_reg       <= '0;
            end
            else if (step)
            begin
                if (step_last)
                begin
                    b_valid_reg <= 1'b0;
                    b_drain_reg <= 1'b0;
                end
                else
                begin
                    b_drain_reg <= 1'b1;
                    k_reg       <= k_reg + HALF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_col_reg        <= col_reg;
            b_v_reg          <= in_data.beyond_bottom ? border_reg : in_data.pixel;
            b_row0_reg       <= (row_reg == '0);
            b_old_border_reg <= (row_reg < ROW_W'(rows_eff));
            b_emit_reg       <= (row_reg >= ROW_W'(h_eff));
            b_row_end_reg    <= row_end_a;
            b_ls_addr_reg    <= ls_rd_addr;
            ls_q_reg         <= ls_mem[ls_rd_addr];
            cs_q_reg         <= cs_mem[col_reg];
        end
        if (step && !b_drain_reg)
        begin
            ls_mem[b_ls_addr_reg] <= b_v_reg;
            cs_mem[b_col_reg]     <= cs_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hist_reg[0] <= b_drain_reg ? bcol_reg : cs_new;
            for (int j = 1; j < SLOTS; j++)
            begin
                hist_reg[j] <= hist_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            out_data_reg.box_sum     <= res_sum;
            out_data_reg.out_col     <= res_col;
            out_data_reg.last_in_run <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire
